// ===== hdl/mtb_pkg.sv =====
`timescale 1ns / 1ps

package mtb_pkg;

  // Block limits and number formats
  localparam int MAX_TARGETS = 6;
  localparam int TIDX_W      = 3;
  localparam int POS_W       = 32;
  localparam int WEIGHT_W    = 16;
  localparam int MASK_W      = 15;
  localparam int ONE_Q14     = 16384;
  localparam int FRAC_Q14    = 14;
  localparam int PROD_W      = POS_W + WEIGHT_W;      // delta * effective weight
  localparam int TERM_W      = PROD_W - FRAC_Q14;     // one weighted delta
  localparam int ACC_W       = TERM_W + 4;            // sum of up to six terms
  localparam int NUM_AXES    = 3;

  // Result buffer
  localparam int OFIFO_DEPTH = 8;
  localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);

  // Configuration register indexes
  typedef enum logic [3:0] {
    CFG_TARGET_COUNT = 4'd0,
    CFG_MASK_ENABLE  = 4'd1,
    CFG_WEIGHT_0     = 4'd2,
    CFG_WEIGHT_1     = 4'd3,
    CFG_WEIGHT_2     = 4'd4,
    CFG_WEIGHT_3     = 4'd5,
    CFG_WEIGHT_4     = 4'd6,
    CFG_WEIGHT_5     = 4'd7
  } cfg_reg_e;

  // Per-beat control that travels alongside the lane data
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mtb_ctrl_t;

  // What one axis lane delivers at the end of a vertex
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             sat;
  } lane_res_t;

  // One buffered result
  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
    logic             sat;
  } out_item_t;

endpackage

// ===== hdl/mtb_lane.sv =====
`timescale 1ns / 1ps

module mtb_lane
  import mtb_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,   // input beat accepted
  input  logic signed [POS_W-1:0]    delta_i,
  input  logic signed [POS_W-1:0]    base_i,
  input  logic signed [WEIGHT_W-1:0] ew_i,     // effective weight, aligned with stage 1
  input  mtb_ctrl_t                  ctrl2_i,  // control of the beat in stage 2
  output lane_res_t                  res_o
);

  logic signed [POS_W-1:0]  delta1_q, base1_q;
  logic signed [PROD_W-1:0] prod2_q, prod_d;
  logic signed [POS_W-1:0]  base2_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [POS_W-1:0]  held_q, base_eff;
  logic signed [ACC_W-1:0]  fin_acc_q;
  logic signed [POS_W-1:0]  fin_base_q;
  logic signed [PROD_W-1:0] rnd_sum;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W:0]    fin_sum;

  // Stage 1: capture the beat
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      delta1_q <= delta_i;
      base1_q  <= base_i;
    end
  end

  // Stage 2: delta times effective weight
  assign prod_d = delta1_q * ew_i;

  always_ff @(posedge clk_i) begin
    prod2_q <= prod_d;
    base2_q <= base1_q;
  end

  // Stage 3: round half up to Q16.16 and accumulate
  assign rnd_sum  = prod2_q + PROD_W'(1 << (FRAC_Q14 - 1));
  assign term     = rnd_sum[PROD_W-1:FRAC_Q14];
  assign acc_d    = (ctrl2_i.first ? '0 : acc_q) + ACC_W'(term);
  assign base_eff = ctrl2_i.first ? base2_q : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      held_q <= '0;
    end else if (ctrl2_i.valid) begin
      acc_q  <= acc_d;
      held_q <= base_eff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl2_i.valid && ctrl2_i.last) begin
      fin_acc_q  <= acc_d;
      fin_base_q <= base_eff;
    end
  end

  // Stage 4: base plus sum, clipped to 32 bits
  assign fin_sum = (ACC_W+1)'(fin_base_q) + (ACC_W+1)'(fin_acc_q);

  always_comb begin
    res_o.sat = 1'b0;
    res_o.pos = fin_sum[POS_W-1:0];
    if (!fin_sum[ACC_W] && (|fin_sum[ACC_W-1:POS_W-1])) begin
      res_o.sat = 1'b1;
      res_o.pos = {1'b0, {(POS_W-1){1'b1}}};
    end else if (fin_sum[ACC_W] && !(&fin_sum[ACC_W-1:POS_W-1])) begin
      res_o.sat = 1'b1;
      res_o.pos = {1'b1, {(POS_W-1){1'b0}}};
    end
  end

endmodule

// ===== hdl/mtb_merge.sv =====
`timescale 1ns / 1ps

module mtb_merge
  import mtb_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  lane_res_t [NUM_AXES-1:0]      res_i,
  output logic [OFIFO_AW:0]             level_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [POS_W-1:0]              out_x_o,
  output logic [POS_W-1:0]              out_y_o,
  output logic [POS_W-1:0]              out_z_o,
  output logic                          saturated_o
);

  out_item_t             fifo_q [OFIFO_DEPTH];
  out_item_t             wr_item;
  logic [OFIFO_AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [OFIFO_AW:0]     cnt_q, cnt_d;
  logic                  pop;

  // Combine the three lanes into one result beat
  always_comb begin
    wr_item.x   = res_i[0].pos;
    wr_item.y   = res_i[1].pos;
    wr_item.z   = res_i[2].pos;
    wr_item.sat = res_i[0].sat | res_i[1].sat | res_i[2].sat;
  end

  // Result buffer
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      fifo_q[wr_ptr_q] <= wr_item;
    end
  end

  assign pop = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_en_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (OFIFO_AW+1)'(wr_en_i) - (OFIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign level_o     = cnt_q;
  assign out_valid_o = (cnt_q != '0);
  assign out_x_o     = fifo_q[rd_ptr_q].x;
  assign out_y_o     = fifo_q[rd_ptr_q].y;
  assign out_z_o     = fifo_q[rd_ptr_q].z;
  assign saturated_o = fifo_q[rd_ptr_q].sat;

  // Checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> (cnt_q < (OFIFO_AW+1)'(OFIFO_DEPTH)))
    else $error("result buffer written while full");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (OFIFO_AW+1)'(OFIFO_DEPTH))
    else $error("result buffer count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != (OFIFO_AW+1)'(OFIFO_DEPTH)) |-> (cnt_q[OFIFO_AW-1:0] == wr_ptr_q - rd_ptr_q))
    else $error("result buffer pointers disagree with count");

endmodule

// ===== hdl/morph_target_blend_core.sv =====
`timescale 1ns / 1ps
// Result path: a vertex's last beat passes lane stages 1-3, then the result buffer.
// Throughput: one input beat per cycle, set by the 4-stage lane pipeline; an 8-entry
//   result buffer lets input keep flowing while results wait, and input stalls once
//   buffered plus in-flight beats reach 8.
// Reset: rst_ni is asynchronous, active low; it restores the register defaults,
//   restarts at target 0 and empties the result buffer.

module morph_target_blend_core
  import mtb_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [3:0]                 cfg_index_i,
  input  logic [WEIGHT_W-1:0]        cfg_data_i,
  // input beats
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [POS_W-1:0]    base_x_i,
  input  logic signed [POS_W-1:0]    base_y_i,
  input  logic signed [POS_W-1:0]    base_z_i,
  input  logic signed [POS_W-1:0]    delta_x_i,
  input  logic signed [POS_W-1:0]    delta_y_i,
  input  logic signed [POS_W-1:0]    delta_z_i,
  input  logic signed [WEIGHT_W-1:0] mask_i,
  // results
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [POS_W-1:0]    out_x_o,
  output logic signed [POS_W-1:0]    out_y_o,
  output logic signed [POS_W-1:0]    out_z_o,
  output logic                       saturated_o
);

  logic [TIDX_W-1:0]          count_q;
  logic                       mask_en_q;
  logic signed [WEIGHT_W-1:0] weight_q [MAX_TARGETS];

  logic [TIDX_W-1:0]          idx_q, idx_d, count_eff;
  logic [MASK_W-1:0]          held_mask_q, mask_eff, mask_clamp;
  logic                       accept, first, last;
  logic signed [2*WEIGHT_W-1:0] wprod_d, wprod_q;
  logic signed [2*WEIGHT_W:0] ew_sum;
  logic signed [WEIGHT_W-1:0] ew;
  mtb_ctrl_t                  ctrl1_q, ctrl2_q;
  logic                       fin_valid_q;
  logic [OFIFO_AW:0]          level, occ;
  lane_res_t [NUM_AXES-1:0]   lane_res;
  logic signed [POS_W-1:0]    delta_a [NUM_AXES];
  logic signed [POS_W-1:0]    base_a  [NUM_AXES];

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= TIDX_W'(1);
      mask_en_q <= 1'b0;
      for (int i = 0; i < MAX_TARGETS; i++) begin
        weight_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_TARGET_COUNT: count_q     <= cfg_data_i[TIDX_W-1:0];
        CFG_MASK_ENABLE:  mask_en_q   <= cfg_data_i[0];
        CFG_WEIGHT_0:     weight_q[0] <= cfg_data_i;
        CFG_WEIGHT_1:     weight_q[1] <= cfg_data_i;
        CFG_WEIGHT_2:     weight_q[2] <= cfg_data_i;
        CFG_WEIGHT_3:     weight_q[3] <= cfg_data_i;
        CFG_WEIGHT_4:     weight_q[4] <= cfg_data_i;
        CFG_WEIGHT_5:     weight_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Target sequencing
  always_comb begin
    if (count_q == '0) begin
      count_eff = TIDX_W'(1);
    end else if (count_q > TIDX_W'(MAX_TARGETS)) begin
      count_eff = TIDX_W'(MAX_TARGETS);
    end else begin
      count_eff = count_q;
    end
  end

  assign occ        = level + (OFIFO_AW+1)'(ctrl1_q.valid) + (OFIFO_AW+1)'(ctrl2_q.valid)
                    + (OFIFO_AW+1)'(fin_valid_q);
  assign in_ready_o = (occ < (OFIFO_AW+1)'(OFIFO_DEPTH));
  assign accept     = in_valid_i && in_ready_o;
  assign first      = (idx_q == '0);
  assign last       = ((idx_q + 1'b1) >= count_eff);
  assign idx_d      = last ? '0 : idx_q + 1'b1;

  // Mask clamp to 0..one, or one when the mask is off; later targets reuse the held mask
  always_comb begin
    if (mask_i[WEIGHT_W-1]) begin
      mask_clamp = '0;
    end else if (mask_i > WEIGHT_W'(ONE_Q14)) begin
      mask_clamp = MASK_W'(ONE_Q14);
    end else begin
      mask_clamp = mask_i[MASK_W-1:0];
    end
    if (!first) begin
      mask_eff = held_mask_q;
    end else if (mask_en_q) begin
      mask_eff = mask_clamp;
    end else begin
      mask_eff = MASK_W'(ONE_Q14);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      held_mask_q <= '0;
    end else if (accept) begin
      idx_q       <= idx_d;
      held_mask_q <= mask_eff;
    end
  end

  // Effective weight: multiply, register, then round half up in stage 1
  assign wprod_d = weight_q[idx_q] * $signed({1'b0, mask_eff});

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wprod_q <= wprod_d;
    end
  end

  assign ew_sum = (2*WEIGHT_W+1)'(wprod_q) + (2*WEIGHT_W+1)'(1 << (FRAC_Q14 - 1));
  assign ew     = ew_sum[FRAC_Q14+WEIGHT_W-1:FRAC_Q14];

  // Control pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q     <= '0;
      ctrl2_q     <= '0;
      fin_valid_q <= 1'b0;
    end else begin
      ctrl1_q     <= '{valid: accept, first: first, last: last};
      ctrl2_q     <= ctrl1_q;
      fin_valid_q <= ctrl2_q.valid && ctrl2_q.last;
    end
  end

  // Axis lanes
  assign delta_a[0] = delta_x_i;
  assign delta_a[1] = delta_y_i;
  assign delta_a[2] = delta_z_i;
  assign base_a[0]  = base_x_i;
  assign base_a[1]  = base_y_i;
  assign base_a[2]  = base_z_i;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    mtb_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (accept),
      .delta_i (delta_a[a]),
      .base_i  (base_a[a]),
      .ew_i    (ew),
      .ctrl2_i (ctrl2_q),
      .res_o   (lane_res[a])
    );
  end

  // Merge lanes and buffer results
  mtb_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (fin_valid_q),
    .res_i       (lane_res),
    .level_o     (level),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .saturated_o (saturated_o)
  );

  // Checks
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < TIDX_W'(MAX_TARGETS))
    else $error("target index beyond target limit");

  a_mask_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_mask_q <= MASK_W'(ONE_Q14))
    else $error("held mask above one");

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> (idx_q == '0))
    else $error("vertex end did not restart target index");

endmodule

// ===== tb/morph_target_blend_core_tb.sv =====
`timescale 1ns / 1ps

module morph_target_blend_core_tb;
  import mtb_pkg::*;

  localparam int            HALF_PERIOD    = 10;
  localparam int            RESET_CYCLES   = 6;
  localparam int            RAND_BEATS     = 1250;
  localparam int            SETTLE_CYCLES  = 12;    // result latency plus slack
  localparam int            SQUEEZE_CYCLES = 300;   // long receiver hold-off
  localparam int            WATCHDOG_LIMIT = 2000;
  localparam logic [3:0]    CFG_FIRST_UNUSED = 4'd8;
  localparam longint        POS_MAX = (64'sd1 <<< 31) - 1;
  localparam longint        POS_MIN = -(64'sd1 <<< 31);
  localparam logic [31:0]   P_MAX = 32'h7fff_ffff;
  localparam logic [31:0]   P_MIN = 32'h8000_0000;

  // One target beat and one blended vertex
  typedef struct packed {
    logic [NUM_AXES-1:0][POS_W-1:0] base;
    logic [NUM_AXES-1:0][POS_W-1:0] delta;
    logic [WEIGHT_W-1:0]            mask;
  } blend_beat_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][POS_W-1:0] pos;
    logic                           sat;
  } blend_res_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [3:0]                 cfg_index_i = '0;
  logic [WEIGHT_W-1:0]        cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [POS_W-1:0]    base_x_i = '0;
  logic signed [POS_W-1:0]    base_y_i = '0;
  logic signed [POS_W-1:0]    base_z_i = '0;
  logic signed [POS_W-1:0]    delta_x_i = '0;
  logic signed [POS_W-1:0]    delta_y_i = '0;
  logic signed [POS_W-1:0]    delta_z_i = '0;
  logic signed [WEIGHT_W-1:0] mask_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [POS_W-1:0]    out_x_o;
  logic signed [POS_W-1:0]    out_y_o;
  logic signed [POS_W-1:0]    out_z_o;
  logic                       saturated_o;

  morph_target_blend_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .base_x_i    (base_x_i),
    .base_y_i    (base_y_i),
    .base_z_i    (base_z_i),
    .delta_x_i   (delta_x_i),
    .delta_y_i   (delta_y_i),
    .delta_z_i   (delta_z_i),
    .mask_i      (mask_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .saturated_o (saturated_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Shadow copy of the block: registers and per-vertex state
  logic [TIDX_W-1:0]         cnt_reg = 3'd1;
  bit                        mask_en = 1'b0;
  logic signed [WEIGHT_W-1:0] wts [MAX_TARGETS];
  int unsigned               tgt_idx = 0;
  logic signed [POS_W-1:0]   held_base [NUM_AXES];
  longint                    held_mask = 0;
  longint                    acc [NUM_AXES];

  blend_beat_t beat_q [$];
  blend_res_t  blended_q [$];
  blend_beat_t cur_beat;
  logic [WEIGHT_W-1:0] plan_w [MAX_TARGETS];

  int  items_left = 0;
  int  beats_accepted = 0;
  int  results_seen = 0;
  int  cfg_writes = 0;
  int  setups = 0;
  int  mismatches = 0;
  int  gap_left = 0;
  int  hold_left = 0;
  int  squeeze_req = 0;
  int  squeeze_seen = 0;
  int  stuck_cycles = 0;
  bit  in_calm = 1'b0;
  bit  out_calm = 1'b0;

  initial begin
    for (int i = 0; i < MAX_TARGETS; i++) wts[i] = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      held_base[a] = '0;
      acc[a] = 0;
    end
  end

  // Random gap: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 9))
      0: return P_MAX;
      1: return P_MIN;
      2: return 32'($urandom_range(0, 8192)) - 32'd4096;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_mask();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      3: return 16'(ONE_Q14);
      4: return 16'($urandom_range(ONE_Q14 + 1, 32767));
      5, 6: return 16'($urandom_range(0, ONE_Q14));
      7: return 16'd0 - 16'($urandom_range(1, 32768));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return '0;
      3: return 16'd0 - 16'($urandom_range(0, 6)) + 16'd3;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic blend_beat_t make_beat(logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                                            logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                            logic [15:0] m);
    blend_beat_t b;
    b.base[0] = bx;
    b.base[1] = by;
    b.base[2] = bz;
    b.delta[0] = dx;
    b.delta[1] = dy;
    b.delta[2] = dz;
    b.mask = m;
    return b;
  endfunction

  function automatic blend_beat_t rand_beat();
    return make_beat(rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos(),
                     rand_mask());
  endfunction

  function automatic int eff_count();
    if (cnt_reg < 1) return 1;
    if (cnt_reg > MAX_TARGETS) return MAX_TARGETS;
    return int'(cnt_reg);
  endfunction

  // Shadow register write; unknown indexes fall through
  function automatic void cfg_apply(logic [3:0] idx, logic [WEIGHT_W-1:0] data);
    if (idx == CFG_TARGET_COUNT) cnt_reg = data[TIDX_W-1:0];
    else if (idx == CFG_MASK_ENABLE) mask_en = data[0];
    else if (idx >= CFG_WEIGHT_0 && idx <= CFG_WEIGHT_5) wts[idx - CFG_WEIGHT_0] = data;
  endfunction

  // Accumulate one target beat; queue the blended vertex on the last one
  function automatic void blend_predict(blend_beat_t b);
    int         count;
    int         m;
    longint     ew;
    longint     d;
    longint     s;
    blend_res_t r;
    count = eff_count();
    ew = 0;
    if (tgt_idx == 0) begin
      m = int'($signed(b.mask));
      for (int a = 0; a < NUM_AXES; a++) begin
        held_base[a] = b.base[a];
        acc[a] = 0;
      end
      if (mask_en) begin
        if (m < 0) m = 0;
        if (m > ONE_Q14) m = ONE_Q14;
        held_mask = m;
      end else begin
        held_mask = ONE_Q14;
      end
    end
    if (tgt_idx < MAX_TARGETS)
      ew = (longint'(wts[tgt_idx]) * held_mask + 64'sd8192) >>> FRAC_Q14;
    if (ew != 0) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        d = longint'($signed(b.delta[a]));
        acc[a] += (d * ew + 64'sd8192) >>> FRAC_Q14;
      end
    end
    if (tgt_idx + 1 >= count) begin
      tgt_idx = 0;
      r.sat = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        s = longint'(held_base[a]) + acc[a];
        if (s > POS_MAX) begin
          s = POS_MAX;
          r.sat = 1'b1;
        end else if (s < POS_MIN) begin
          s = POS_MIN;
          r.sat = 1'b1;
        end
        r.pos[a] = s[POS_W-1:0];
      end
      blended_q.push_back(r);
    end else begin
      tgt_idx = (tgt_idx + 1) & 7;
    end
  endfunction

  // Input driver: one beat in flight, held until accepted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        blend_predict(cur_beat);
        items_left--;
        beats_accepted++;
      end
      if (in_valid_i && !in_ready_o) begin
        // stalled: keep the beat on the bus
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (beat_q.size() != 0) begin
        cur_beat = beat_q.pop_front();
        base_x_i <= cur_beat.base[0];
        base_y_i <= cur_beat.base[1];
        base_z_i <= cur_beat.base[2];
        delta_x_i <= cur_beat.delta[0];
        delta_y_i <= cur_beat.delta[1];
        delta_z_i <= cur_beat.delta[2];
        mask_i <= cur_beat.mask;
        in_valid_i <= 1'b1;
        gap_left = in_calm ? 0 : gap_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Compare one result beat with the oldest predicted vertex
  task automatic check_result();
    blend_res_t want;
    logic [NUM_AXES-1:0][POS_W-1:0] got;
    got[0] = out_x_o;
    got[1] = out_y_o;
    got[2] = out_z_o;
    results_seen++;
    if (blended_q.size() == 0) begin
      $display("%0t: unexpected result x=%h y=%h z=%h sat=%b", $time, got[0], got[1], got[2],
               saturated_o);
      mismatches++;
    end else begin
      want = blended_q.pop_front();
      for (int a = 0; a < NUM_AXES; a++) begin
        if (got[a] !== want.pos[a]) begin
          $display("%0t: axis %0d expected %h actual %h", $time, a, want.pos[a], got[a]);
          mismatches++;
        end
      end
      if (saturated_o !== want.sat) begin
        $display("%0t: saturated expected %b actual %b", $time, want.sat, saturated_o);
        mismatches++;
      end
    end
  endtask

  // Result monitor with random backpressure and one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_result();
      if (squeeze_req != squeeze_seen) begin
        squeeze_seen = squeeze_req;
        hold_left = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!out_calm && $urandom_range(0, 99) < 20) hold_left = gap_len();
      end
    end
  end

  // Watchdog: no beat on any channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, nothing moved for %0d cycles", $time, stuck_cycles);
        $display("TB_ERROR");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // Register write; valid stays up for the next write of a batch
  task automatic cfg_write(input logic [3:0] idx, input logic [WEIGHT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_apply(idx, data);
    cfg_writes++;
  endtask

  task automatic program_regs(input logic [WEIGHT_W-1:0] cnt_data,
                              input logic [WEIGHT_W-1:0] en_data, input bit poke_unused);
    cfg_write(CFG_TARGET_COUNT, cnt_data);
    cfg_write(CFG_MASK_ENABLE, en_data);
    for (int w = 0; w < MAX_TARGETS; w++) cfg_write(CFG_WEIGHT_0 + 4'(w), plan_w[w]);
    if (poke_unused) cfg_write(CFG_FIRST_UNUSED + 4'($urandom_range(0, 7)), 16'($urandom()));
    cfg_valid_i <= 1'b0;
    setups++;
  endtask

  task automatic push_beat(input blend_beat_t b);
    beat_q.push_back(b);
    items_left++;
  endtask

  // Wait for every beat and result, then let the pipeline settle
  task automatic wait_idle();
    while (items_left != 0 || blended_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void set_weights(logic [15:0] w0, logic [15:0] w1, logic [15:0] w2,
                                      logic [15:0] w3, logic [15:0] w4, logic [15:0] w5);
    plan_w[0] = w0;
    plan_w[1] = w1;
    plan_w[2] = w2;
    plan_w[3] = w3;
    plan_w[4] = w4;
    plan_w[5] = w5;
  endfunction

  initial begin
    int n_vert;
    int extra;
    int phase_no;
    int queued;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: one target, zero weight, so out equals base
    push_beat(make_beat(P_MAX, P_MIN, 32'd0, P_MAX, P_MAX, P_MIN, 16'h8000));
    push_beat(rand_beat());
    wait_idle();

    // Three targets, mask on: clamp from above, clamp to zero, tiny mask rounding
    set_weights(16'h7fff, 16'h8000, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    program_regs(16'h0003, 16'h0001, 1'b0);
    push_beat(make_beat(32'h7fff_0000, P_MIN, 32'd0, P_MAX, P_MIN, 32'd12345, 16'h7fff));
    push_beat(make_beat(P_MIN, P_MIN, P_MIN, P_MIN, P_MAX, P_MIN, 16'h0000));
    push_beat(make_beat(P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, 16'h0000));
    push_beat(make_beat(32'h1234_5678, P_MIN, P_MAX, P_MAX, P_MIN, P_MAX, 16'h8000));
    push_beat(rand_beat());
    push_beat(rand_beat());
    push_beat(make_beat(P_MIN, P_MAX, 32'd0, P_MAX, P_MIN, 32'd3, 16'h0001));
    push_beat(make_beat(P_MIN, P_MAX, 32'd0, P_MAX, P_MIN, 32'hffff_fffd, 16'h0001));
    push_beat(make_beat(P_MIN, P_MAX, 32'd0, P_MAX, P_MIN, 32'd7, 16'h0001));
    wait_idle();

    // Count of zero acts as one; writes past the register list are dropped
    set_weights(16'h4000, 16'hc000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    cfg_write(CFG_FIRST_UNUSED, 16'hffff);
    cfg_write(4'hf, 16'h5555);
    program_regs(16'hfff8, 16'hfffe, 1'b1);
    push_beat(rand_beat());
    push_beat(rand_beat());
    wait_idle();

    // Count of seven acts as six, mask off; then leave a vertex half done
    set_weights(16'h7fff, 16'h8000, 16'h0000, 16'h7fff, 16'h8000, 16'h0001);
    program_regs(16'h0007, 16'h0000, 1'b0);
    for (int i = 0; i < MAX_TARGETS + 3; i++) push_beat(rand_beat());
    wait_idle();

    // Count drops mid-vertex and mask enable flips after the mask was latched
    program_regs(16'h0002, 16'h0001, 1'b0);
    push_beat(rand_beat());
    push_beat(make_beat(P_MAX, P_MAX, P_MAX, P_MAX, P_MIN, 32'd0, 16'(ONE_Q14)));
    push_beat(make_beat(P_MIN, P_MIN, P_MIN, P_MAX, P_MIN, 32'd0, 16'(ONE_Q14)));
    wait_idle();

    // Random configurations, mostly whole vertices with some broken tails
    phase_no = 0;
    queued = 0;
    while (queued < RAND_BEATS) begin
      phase_no++;
      for (int w = 0; w < MAX_TARGETS; w++) plan_w[w] = rand_weight();
      in_calm = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      if (phase_no == 3) begin
        // fill the block while the receiver holds off
        in_calm = 1'b1;
        program_regs({13'($urandom()), 3'd1}, 16'($urandom()), 1'b0);
        squeeze_req++;
        n_vert = 80;
        extra = 0;
      end else begin
        program_regs({13'($urandom()), 3'($urandom_range(0, 7))}, 16'($urandom()),
                     ($urandom_range(0, 4) == 0));
        n_vert = $urandom_range(4, 30);
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
      end
      for (int i = 0; i < n_vert * eff_count() + extra; i++) begin
        push_beat(rand_beat());
        queued++;
      end
      wait_idle();
    end

    if (blended_q.size() != 0) begin
      $display("%0t: %0d predicted vertices never came out", $time, blended_q.size());
      mismatches++;
    end
    $display("covered %0d target beats, %0d blended vertices, %0d register writes in %0d setups",
             beats_accepted, results_seen, cfg_writes, setups);
    $display("incl. count 0 and 7, mask clamp/disable/latch, mid-vertex count change, long stall");
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
